// ----- sv/ssr_pkg.sv -----
// ----------------------------------------------------------------------------
// ssr_pkg: shared definitions for the streaming substring replace block
// Field widths, configuration register indexes, the compare result record
// and the ASCII case folding function.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int BYTE_W     = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_BYTES  = CFG_DATA_W / BYTE_W;
  localparam int BYTE_IDX_W = $clog2(CFG_BYTES);
  localparam int LEN_W      = 4;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_CASE       = 3'd4;

  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_NUL     = 8'h00;

  // Verdict of the prefix compare unit on the pending buffer.
  typedef struct packed {
    logic full;  // buffer holds the whole pattern
    logic hold;  // buffer is a proper prefix of the pattern
  } match_t;

  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c,
                                                  input logic ic);
    logic [BYTE_W-1:0] res;
    res = c;
    if (ic && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
      res = c + CASE_OFFSET;
    end
    return res;
  endfunction

endpackage

// ----- sv/ssr_match.sv -----
// ----------------------------------------------------------------------------
// ssr_match: prefix compare unit
// Compares every in-use byte of the pending buffer against the pattern in
// one pass and reports a full match or a live partial match.
// ----------------------------------------------------------------------------
module ssr_match #(
  parameter int MAX_PATTERN = 8
) (
  input  logic [ssr_pkg::BYTE_W-1:0]     pend [MAX_PATTERN],
  input  logic [$clog2(MAX_PATTERN+1)-1:0] count,
  input  logic [ssr_pkg::CFG_DATA_W-1:0] pat_bytes,
  input  logic [ssr_pkg::LEN_W-1:0]      plen,
  input  logic                           ignore_case,
  output ssr_pkg::match_t                mt
);

  localparam int CW = $clog2(MAX_PATTERN + 1);

  logic [MAX_PATTERN-1:0] eq;
  logic [MAX_PATTERN-1:0] in_use;
  logic                   prefix_ok;
  logic [ssr_pkg::LEN_W-1:0] count_ext;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cmp
    assign eq[i] = ssr_pkg::fold_case(pend[i], ignore_case) ==
                   ssr_pkg::fold_case(pat_bytes[i*ssr_pkg::BYTE_W +: ssr_pkg::BYTE_W],
                                      ignore_case);
    assign in_use[i] = CW'(i) < count;
  end

  assign prefix_ok = &(eq | ~in_use);
  assign count_ext = ssr_pkg::LEN_W'(count);

  always_comb begin
    mt.full = (plen != '0) && (count_ext == plen) && prefix_ok;
    mt.hold = (plen != '0) && (count_ext < plen) && prefix_ok;
  end

endmodule

// ----- sv/stream_substring_replace_top.sv -----
// A byte is taken in the idle state and judged in the check state that
// follows. A full match sends the replacement bytes, a hold waits for the
// next byte, and a buffer that is no longer a pattern prefix releases its
// oldest byte and is judged again; output stalls hold every send. A zero
// byte releases the pending bytes, then the terminator. One request at a
// time; synchronous active-low reset clears registers, pending count, out_valid.
// ----------------------------------------------------------------------------
// stream_substring_replace_top: streaming find-and-replace
// Holds bytes that may start a match, replaces each full match, releases bytes
// oldest first once the buffer stops being a pattern prefix or on a zero byte.
// ----------------------------------------------------------------------------
module stream_substring_replace_top #(
  parameter int MAX_PATTERN = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ssr_pkg::BYTE_W-1:0]      in_char_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ssr_pkg::BYTE_W-1:0]      out_char,
  output logic                            out_end_of_string,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [ssr_pkg::LEN_W-1:0] MAX_LEN = ssr_pkg::LEN_W'(MAX_PATTERN);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_REPL  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [ssr_pkg::CFG_DATA_W-1:0]   pat_bytes_r, rep_bytes_r;
  logic [ssr_pkg::LEN_W-1:0]        pat_len_r, rep_len_r;
  logic                             ignore_case_r;
  logic [ssr_pkg::BYTE_W-1:0]       pend_r [MAX_PATTERN];
  logic [CW-1:0]                    count_r, count_nxt;
  logic [ssr_pkg::BYTE_IDX_W-1:0]   rep_idx_r, rep_idx_nxt;
  logic                             out_valid_r;
  logic [ssr_pkg::BYTE_W-1:0]       out_char_r;
  logic                             out_eos_r;

  logic [ssr_pkg::LEN_W-1:0]        plen, rlen;
  logic                             out_free;
  logic                             pend_wr, pend_shift;
  logic                             out_load;
  logic [ssr_pkg::BYTE_W-1:0]       load_char;
  logic                             load_eos;
  ssr_pkg::match_t                  mt;

  assign plen      = (pat_len_r > MAX_LEN) ? MAX_LEN : pat_len_r;
  assign rlen      = (rep_len_r > MAX_LEN) ? MAX_LEN : rep_len_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  ssr_match #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_match (
    .pend        (pend_r),
    .count       (count_r),
    .pat_bytes   (pat_bytes_r),
    .plen        (plen),
    .ignore_case (ignore_case_r),
    .mt          (mt)
  );

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r   <= '0;
      pat_len_r     <= '0;
      rep_bytes_r   <= '0;
      rep_len_r     <= '0;
      ignore_case_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ssr_pkg::REG_PATTERN_BYTES:      pat_bytes_r   <= cfg_data;
        ssr_pkg::REG_PATTERN_LENGTH:     pat_len_r     <= cfg_data[ssr_pkg::LEN_W-1:0];
        ssr_pkg::REG_REPLACEMENT_BYTES:  rep_bytes_r   <= cfg_data;
        ssr_pkg::REG_REPLACEMENT_LENGTH: rep_len_r     <= cfg_data[ssr_pkg::LEN_W-1:0];
        ssr_pkg::REG_IGNORE_CASE:        ignore_case_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    rep_idx_nxt = rep_idx_r;
    pend_wr     = 1'b0;
    pend_shift  = 1'b0;
    out_load    = 1'b0;
    load_char   = ssr_pkg::CHAR_NUL;
    load_eos    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_char_value == ssr_pkg::CHAR_NUL) begin
            state_nxt = ST_FLUSH;
          end else begin
            pend_wr   = 1'b1;
            count_nxt = count_r + CW'(1);
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (mt.full) begin
          count_nxt   = '0;
          rep_idx_nxt = '0;
          state_nxt   = (rlen == '0) ? ST_IDLE : ST_REPL;
        end else if (mt.hold) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          // The buffer is no longer a prefix: release the oldest byte and
          // judge the rest again in the next cycle.
          out_load   = 1'b1;
          load_char  = pend_r[0];
          pend_shift = 1'b1;
          count_nxt  = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_REPL: begin
        if (out_free) begin
          out_load    = 1'b1;
          load_char   = rep_bytes_r[{rep_idx_r, 3'b000} +: ssr_pkg::BYTE_W];
          rep_idx_nxt = rep_idx_r + ssr_pkg::BYTE_IDX_W'(1);
          if ((ssr_pkg::LEN_W'(rep_idx_r) + ssr_pkg::LEN_W'(1)) == rlen) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          if (count_r != '0) begin
            load_char  = pend_r[0];
            pend_shift = 1'b1;
            count_nxt  = count_r - CW'(1);
          end else begin
            load_char = ssr_pkg::CHAR_NUL;
            load_eos  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rep_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rep_idx_r <= rep_idx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char_r <= load_char;
      out_eos_r  <= load_eos;
    end
  end

  // Pending buffer: written at the fill position, shifted toward entry zero.
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pend
    always_ff @(posedge clk) begin
      if (pend_wr && (count_r[IW-1:0] == IW'(i))) begin
        pend_r[i] <= in_char_value;
      end else if (pend_shift) begin
        pend_r[i] <= pend_r[(i < MAX_PATTERN - 1) ? i + 1 : i];
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_char          = out_char_r;
  assign out_end_of_string = out_eos_r;

endmodule

// ----- sv/ssr_checker.sv -----
// ----------------------------------------------------------------------------
// ssr_checker: port-level checks for the substring replace block
// Watches the top level's ports and is attached to it by a bind statement.
// ----------------------------------------------------------------------------
module ssr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [ssr_pkg::BYTE_W-1:0]     out_char,
  input logic                           out_end_of_string
);

  // Each request keeps the block busy for at least the following cycle.
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block took a request in the cycle after a request");

  // The terminator always carries a zero byte.
  a_terminator_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_string |-> out_char == ssr_pkg::CHAR_NUL)
    else $error("terminator result with a nonzero byte");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char) &&
                               $stable(out_end_of_string))
    else $error("stalled result changed");

  // Reset leaves no result pending and the input side open.
  a_reset_state: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind stream_substring_replace_top ssr_checker u_ssr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_char          (out_char),
  .out_end_of_string (out_end_of_string)
);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the streaming substring replace block
// Streams zero-terminated text through the block under a series of pattern,
// replacement and case settings. Every output byte is predicted on the fly
// and compared in order, while both handshakes are throttled at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int PAT_MAX          = 8;
  localparam int NUM_RANDOM_CHARS = 430;
  localparam int MAX_GAP          = 11;
  localparam int SETTLE_CYCLES    = 24;
  localparam int END_CYCLES       = 40;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int MAX_SHOWN        = 10;

  localparam logic [ssr_pkg::BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [ssr_pkg::BYTE_W-1:0] CHAR_LOWER_Z = 8'h7A;

  typedef struct packed {
    logic [ssr_pkg::BYTE_W-1:0] ch;
    logic                       eos;
  } text_out_t;

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [ssr_pkg::BYTE_W-1:0]     in_char_value = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [ssr_pkg::BYTE_W-1:0]     out_char;
  logic                           out_end_of_string;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ssr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted copy of the registers and of the held match buffer.
  logic [ssr_pkg::CFG_DATA_W-1:0] pattern_text = '0;
  logic [ssr_pkg::LEN_W-1:0]      pattern_len = '0;
  logic [ssr_pkg::CFG_DATA_W-1:0] subst_text = '0;
  logic [ssr_pkg::LEN_W-1:0]      subst_len = '0;
  logic                           fold_on = 1'b0;
  logic [ssr_pkg::BYTE_W-1:0]     held_text [0:PAT_MAX] = '{default: '0};
  int                             held_count = 0;

  logic [ssr_pkg::BYTE_W-1:0] text_q [$];
  text_out_t                  expected_text_q [$];

  bit calm = 1'b0;
  int in_gap = 0;
  int stall_left = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  stream_substring_replace_top #(.MAX_PATTERN(PAT_MAX)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_value    (in_char_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_end_of_string(out_end_of_string),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int clamp_len(input logic [ssr_pkg::LEN_W-1:0] len);
    return (len > PAT_MAX) ? PAT_MAX : int'(len);
  endfunction

  function automatic logic [ssr_pkg::BYTE_W-1:0] to_lower(
      input logic [ssr_pkg::BYTE_W-1:0] c);
    if (fold_on && c >= ssr_pkg::CHAR_UPPER_A && c <= ssr_pkg::CHAR_UPPER_Z) begin
      return c | ssr_pkg::CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic bit held_is_prefix(input int n);
    for (int i = 0; i < n; i++) begin
      if (to_lower(held_text[i]) !=
          to_lower(pattern_text[i*ssr_pkg::BYTE_W +: ssr_pkg::BYTE_W])) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void note_out(input logic [ssr_pkg::BYTE_W-1:0] ch, input logic eos);
    text_out_t r;
    r.ch  = ch;
    r.eos = eos;
    expected_text_q.push_back(r);
  endfunction

  // Works out the output bytes that one accepted request produces.
  function automatic void replace_step(input logic [ssr_pkg::BYTE_W-1:0] c);
    int plen;
    int rlen;
    plen = clamp_len(pattern_len);
    rlen = clamp_len(subst_len);
    if (held_count > PAT_MAX - 1) held_count = PAT_MAX - 1;
    if (c == ssr_pkg::CHAR_NUL) begin
      for (int i = 0; i < held_count; i++) note_out(held_text[i], 1'b0);
      held_count = 0;
      note_out(ssr_pkg::CHAR_NUL, 1'b1);
      return;
    end
    held_text[held_count] = c;
    held_count++;
    while (held_count > 0) begin
      if (plen > 0 && held_count == plen && held_is_prefix(plen)) begin
        for (int i = 0; i < rlen; i++) begin
          note_out(subst_text[i*ssr_pkg::BYTE_W +: ssr_pkg::BYTE_W], 1'b0);
        end
        held_count = 0;
      end else if (plen > 0 && held_count < plen && held_is_prefix(held_count)) begin
        break;
      end else begin
        // The buffer is no longer a pattern prefix: release the oldest byte.
        note_out(held_text[0], 1'b0);
        for (int i = 1; i < held_count; i++) held_text[i-1] = held_text[i];
        held_count--;
      end
    end
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Driver: one request per handshake, a random pause drawn for each one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) replace_step(in_char_value);
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (text_q.size() > 0) begin
        in_valid      <= 1'b1;
        in_char_value <= text_q.pop_front();
        in_gap        <= draw_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each output byte and then stalls for a random time.
  always @(posedge clk) begin : monitor
    text_out_t want;
    int        hold;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_text_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("unexpected output: char %h eos %b", out_char, out_end_of_string);
        end
      end else begin
        want = expected_text_q.pop_front();
        if (out_char !== want.ch || out_end_of_string !== want.eos) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("mismatch: expected char %h eos %b, got char %h eos %b",
                     want.ch, want.eos, out_char, out_end_of_string);
          end
        end
      end
      hold = draw_wait();
      stall_left <= hold;
      out_stall  <= (hold != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [ssr_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [ssr_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      ssr_pkg::REG_PATTERN_BYTES:      pattern_text = value;
      ssr_pkg::REG_PATTERN_LENGTH:     pattern_len  = value[ssr_pkg::LEN_W-1:0];
      ssr_pkg::REG_REPLACEMENT_BYTES:  subst_text   = value;
      ssr_pkg::REG_REPLACEMENT_LENGTH: subst_len    = value[ssr_pkg::LEN_W-1:0];
      ssr_pkg::REG_IGNORE_CASE:        fold_on      = value[0];
      default: ;
    endcase
  endtask

  // Indexes past the last register must leave the settings alone.
  task automatic write_unused(input logic [ssr_pkg::CFG_DATA_W-1:0] value);
    for (int r = int'(ssr_pkg::REG_IGNORE_CASE) + 1; r < 2**ssr_pkg::CFG_IDX_W; r++) begin
      write_reg(ssr_pkg::CFG_IDX_W'(r), value);
    end
  endtask

  // Waits until every request is taken and every byte has come out, then
  // lets the block finish any request that produces nothing.
  task automatic drain();
    do @(negedge clk); while (text_q.size() != 0 || in_valid || expected_text_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_string(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  function automatic bit is_letter(input logic [ssr_pkg::BYTE_W-1:0] c);
    return (c >= ssr_pkg::CHAR_UPPER_A && c <= ssr_pkg::CHAR_UPPER_Z) ||
           (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
  endfunction

  function automatic logic [ssr_pkg::BYTE_W-1:0] vary_case(
      input logic [ssr_pkg::BYTE_W-1:0] c);
    if (is_letter(c) && $urandom_range(0, 1) == 1) return c ^ ssr_pkg::CASE_OFFSET;
    return c;
  endfunction

  // Pattern bytes lean on a few letters of both cases and on the characters
  // right next to the letter ranges, so that folding is exercised.
  function automatic logic [ssr_pkg::BYTE_W-1:0] pattern_char();
    logic [ssr_pkg::BYTE_W-1:0] border_chars [4] = '{8'h40, 8'h5B, 8'h60, 8'h7B};
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return vary_case(CHAR_LOWER_A + ssr_pkg::BYTE_W'($urandom_range(0, 3)));
    if (pick < 8) return border_chars[$urandom_range(0, 3)];
    return ssr_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [ssr_pkg::LEN_W-1:0] draw_length();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick < 7) return ssr_pkg::LEN_W'($urandom_range(1, 4));
    if (pick < 9) return ssr_pkg::LEN_W'($urandom_range(5, PAT_MAX));
    return ssr_pkg::LEN_W'($urandom_range(PAT_MAX + 1, 2**ssr_pkg::LEN_W - 1));
  endfunction

  // Mostly pattern text, as whole or broken-off copies and single pattern bytes,
  // with some noise and an occasional end of string.
  function automatic void queue_text(input int count);
    int plen;
    int made;
    int pick;
    int cut;
    int j;
    plen = clamp_len(pattern_len);
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (plen > 0 && pick < 40) begin
        cut = (pick < 28) ? plen : $urandom_range(1, plen);
        for (int i = 0; i < cut; i++) begin
          text_q.push_back(vary_case(pattern_text[i*ssr_pkg::BYTE_W +: ssr_pkg::BYTE_W]));
        end
        made += cut;
      end else if (plen > 0 && pick < 70) begin
        j = $urandom_range(0, plen - 1);
        text_q.push_back(vary_case(pattern_text[j*ssr_pkg::BYTE_W +: ssr_pkg::BYTE_W]));
        made++;
      end else if (pick < 94) begin
        text_q.push_back(ssr_pkg::BYTE_W'($urandom_range(1, 255)));
        made++;
      end else begin
        text_q.push_back(ssr_pkg::CHAR_NUL);
        made++;
      end
    end
  endfunction

  initial begin
    logic [ssr_pkg::CFG_DATA_W-1:0] pat;
    int made;
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings have an empty pattern, so text passes straight through.
    @(negedge clk);
    text_q.push_back(8'hFF);
    text_q.push_back(8'h80);
    text_q.push_back(8'h01);
    text_q.push_back(8'h7F);
    text_q.push_back(ssr_pkg::CHAR_NUL);
    drain();

    // A repeated first letter forces a re-scan; "ab" is left held at the end.
    write_reg(ssr_pkg::REG_PATTERN_BYTES, 64'h636261);
    write_reg(ssr_pkg::REG_PATTERN_LENGTH, 64'd3);
    write_reg(ssr_pkg::REG_REPLACEMENT_BYTES, 64'h5958);
    write_reg(ssr_pkg::REG_REPLACEMENT_LENGTH, 64'd2);
    @(negedge clk);
    push_string("aabcab");
    drain();

    // New pattern under the held bytes, case folded, matches deleted.
    write_reg(ssr_pkg::REG_PATTERN_BYTES, 64'h7162);
    write_reg(ssr_pkg::REG_PATTERN_LENGTH, 64'd2);
    write_reg(ssr_pkg::REG_REPLACEMENT_LENGTH, 64'd0);
    write_reg(ssr_pkg::REG_IGNORE_CASE, 64'd1);
    write_unused('1);
    @(negedge clk);
    push_string("Q`@{");
    text_q.push_back(ssr_pkg::CHAR_NUL);
    drain();

    // Oversized lengths clamp to the full eight bytes.
    write_reg(ssr_pkg::REG_PATTERN_BYTES, '1);
    write_reg(ssr_pkg::REG_PATTERN_LENGTH, ssr_pkg::CFG_DATA_W'(2**ssr_pkg::LEN_W - 1));
    write_reg(ssr_pkg::REG_REPLACEMENT_BYTES, 64'h0807060504030201);
    write_reg(ssr_pkg::REG_REPLACEMENT_LENGTH, ssr_pkg::CFG_DATA_W'(PAT_MAX + 1));
    write_reg(ssr_pkg::REG_IGNORE_CASE, 64'd0);
    write_unused('0);
    @(negedge clk);
    repeat (PAT_MAX) text_q.push_back(8'hFF);
    text_q.push_back(ssr_pkg::CHAR_NUL);
    drain();

    // Random settings; held bytes carry over from one setting to the next.
    made = 0;
    while (made < NUM_RANDOM_CHARS) begin
      for (int i = 0; i < PAT_MAX; i++) pat[i*ssr_pkg::BYTE_W +: ssr_pkg::BYTE_W] = pattern_char();
      write_reg(ssr_pkg::REG_PATTERN_BYTES, pat);
      write_reg(ssr_pkg::REG_PATTERN_LENGTH, ssr_pkg::CFG_DATA_W'(draw_length()));
      write_reg(ssr_pkg::REG_REPLACEMENT_BYTES, {$urandom, $urandom});
      write_reg(ssr_pkg::REG_REPLACEMENT_LENGTH, ssr_pkg::CFG_DATA_W'(draw_length()));
      write_reg(ssr_pkg::REG_IGNORE_CASE, ssr_pkg::CFG_DATA_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) write_unused({$urandom, $urandom});
      calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(25, 60);
      @(negedge clk);
      queue_text(n);
      made += n;
      drain();
    end

    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
